[hdl/lfsg_pkg.sv]
// ----------------------------------------------------------------------------
// lfsg_pkg
// Shared types and constants of the LED frame sampler with color correction.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsg_pkg;

  // Defaults of the top level parameters
  localparam int LedColumnsDef    = 16;
  localparam int LedRowsDef       = 16;
  localparam int MaxSourceSideDef = 4096;

  // Fixed widths of the configuration port
  localparam int CfgDataW  = 16;
  localparam int CfgIndexW = 3;

  // Queue depths
  localparam int MidDepth = 4;
  localparam int OutDepth = 8;

  // Register reset values
  localparam logic [12:0] SideRst   = 13'd64;
  localparam logic [15:0] GainRst   = 16'd256;
  localparam logic [8:0]  BrightMax = 9'd256;

  // Gamma table channel codes
  localparam logic [1:0] ChanRed   = 2'd0;
  localparam logic [1:0] ChanGreen = 2'd1;
  localparam logic [1:0] ChanBlue  = 2'd2;

  // Register indexes
  typedef enum logic [CfgIndexW-1:0] {
    RegSourceWidth  = 3'd0,
    RegSourceHeight = 3'd1,
    RegRedGain      = 3'd2,
    RegGreenGain    = 3'd3,
    RegBlueGain     = 3'd4,
    RegBrightness   = 3'd5
  } reg_index_e;

  // Color correction settings seen by the back end
  typedef struct packed {
    logic [15:0] red_gain;
    logic [15:0] green_gain;
    logic [15:0] blue_gain;
    logic [8:0]  brightness;
  } corr_cfg_t;

  // Work item between front and back end
  typedef struct packed {
    logic       is_load;
    logic [1:0] chan;
    logic [7:0] idx;
    logic [7:0] val;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] pos;
    logic       last;
  } item_t;

  // Finished result
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] pos;
    logic       last;
  } out_t;

endpackage

`default_nettype wire

[hdl/lfsg_fifo.sv]
// ----------------------------------------------------------------------------
// lfsg_fifo
// Small flop based queue between the front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsg_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[hdl/lfsg_cfg.sv]
// ----------------------------------------------------------------------------
// lfsg_cfg
// Configuration registers; derives the clamped frame size and cell size
// when a size register is written.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsg_cfg #(
  parameter int LED_COLUMNS     = lfsg_pkg::LedColumnsDef,
  parameter int LED_ROWS        = lfsg_pkg::LedRowsDef,
  parameter int MAX_SOURCE_SIDE = lfsg_pkg::MaxSourceSideDef,
  localparam int SideW          = $clog2(MAX_SOURCE_SIDE + 1)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_write,
  input  wire logic [lfsg_pkg::CfgIndexW-1:0]    cfg_index,
  input  wire logic [lfsg_pkg::CfgDataW-1:0]     cfg_data,
  output logic      [SideW-1:0]                  width_o,
  output logic      [SideW-1:0]                  height_o,
  output logic      [SideW-1:0]                  cell_w_o,
  output logic      [SideW-1:0]                  cell_h_o,
  output lfsg_pkg::corr_cfg_t                    corr_o
);

  // Reciprocal constants: exact quotient for any SideW bit dividend
  localparam int ColShift = SideW + $clog2(LED_COLUMNS);
  localparam int RowShift = SideW + $clog2(LED_ROWS);
  localparam int ColRecW  = ColShift + 1;
  localparam int RowRecW  = RowShift + 1;
  localparam logic [ColRecW-1:0] ColRecip =
    ColRecW'(((64'd1 << ColShift) + 64'(LED_COLUMNS) - 64'd1) / 64'(LED_COLUMNS));
  localparam logic [RowRecW-1:0] RowRecip =
    RowRecW'(((64'd1 << RowShift) + 64'(LED_ROWS) - 64'd1) / 64'(LED_ROWS));

  localparam logic [SideW-1:0] SideRstW = SideW'(lfsg_pkg::SideRst);
  localparam logic [SideW-1:0] CellWRst = SideW'(32'(lfsg_pkg::SideRst) / LED_COLUMNS);
  localparam logic [SideW-1:0] CellHRst = SideW'(32'(lfsg_pkg::SideRst) / LED_ROWS);

  logic [SideW-1:0]         side_in;
  logic [SideW+ColRecW-1:0] col_prod;
  logic [SideW+RowRecW-1:0] row_prod;
  logic [SideW+ColRecW-1:0] col_quot;
  logic [SideW+RowRecW-1:0] row_quot;
  logic [8:0]               bright_in;

  lfsg_pkg::reg_index_e     index;

  assign index = lfsg_pkg::reg_index_e'(cfg_index);

  // Clamp written size to 1 .. MAX_SOURCE_SIDE
  always_comb begin
    logic [31:0] v;
    v = 32'(cfg_data[12:0]);
    if (v == 32'd0) begin
      v = 32'd1;
    end else if (v > 32'(MAX_SOURCE_SIDE)) begin
      v = 32'(MAX_SOURCE_SIDE);
    end
    side_in = v[SideW-1:0];
  end

  // Divide by the LED count through the reciprocal
  assign col_prod = (SideW+ColRecW)'(side_in) * (SideW+ColRecW)'(ColRecip);
  assign row_prod = (SideW+RowRecW)'(side_in) * (SideW+RowRecW)'(RowRecip);
  assign col_quot = col_prod >> ColShift;
  assign row_quot = row_prod >> RowShift;

  // Saturate brightness at full scale
  assign bright_in = (cfg_data[8:0] > lfsg_pkg::BrightMax) ? lfsg_pkg::BrightMax
                                                           : cfg_data[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_o           <= SideRstW;
      height_o          <= SideRstW;
      cell_w_o          <= CellWRst;
      cell_h_o          <= CellHRst;
      corr_o.red_gain   <= lfsg_pkg::GainRst;
      corr_o.green_gain <= lfsg_pkg::GainRst;
      corr_o.blue_gain  <= lfsg_pkg::GainRst;
      corr_o.brightness <= lfsg_pkg::BrightMax;
    end else if (cfg_write) begin
      unique case (index)
        lfsg_pkg::RegSourceWidth: begin
          width_o  <= side_in;
          cell_w_o <= col_quot[SideW-1:0];
        end
        lfsg_pkg::RegSourceHeight: begin
          height_o <= side_in;
          cell_h_o <= row_quot[SideW-1:0];
        end
        lfsg_pkg::RegRedGain:    corr_o.red_gain   <= cfg_data;
        lfsg_pkg::RegGreenGain:  corr_o.green_gain <= cfg_data;
        lfsg_pkg::RegBlueGain:   corr_o.blue_gain  <= cfg_data;
        lfsg_pkg::RegBrightness: corr_o.brightness <= bright_in;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/lfsg_front.sv]
// ----------------------------------------------------------------------------
// lfsg_front
// Accepts items, tracks the raster and LED cell position, and forwards
// table loads and cell center pixels to the back end queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsg_front #(
  parameter int LED_COLUMNS     = lfsg_pkg::LedColumnsDef,
  parameter int LED_ROWS        = lfsg_pkg::LedRowsDef,
  parameter int MAX_SOURCE_SIDE = lfsg_pkg::MaxSourceSideDef,
  localparam int SideW          = $clog2(MAX_SOURCE_SIDE + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire logic             action_i,
  input  wire logic             frame_start_i,
  input  wire logic [7:0]       pixel_red_i,
  input  wire logic [7:0]       pixel_green_i,
  input  wire logic [7:0]       pixel_blue_i,
  input  wire logic [1:0]       table_channel_i,
  input  wire logic [7:0]       table_index_i,
  input  wire logic [7:0]       table_value_i,
  input  wire logic [SideW-1:0] width_i,
  input  wire logic [SideW-1:0] height_i,
  input  wire logic [SideW-1:0] cell_w_i,
  input  wire logic [SideW-1:0] cell_h_i,
  output logic                  enq_o,
  output lfsg_pkg::item_t       item_o,
  input  wire logic             queue_full_i
);

  localparam int ColW = $clog2(LED_COLUMNS + 1);
  localparam int RowW = $clog2(LED_ROWS + 1);

  logic [SideW-1:0] src_col_q, src_col_d, src_row_q, src_row_d;
  logic [SideW-1:0] col_ph_q, col_ph_d, row_ph_q, row_ph_d;
  logic [ColW-1:0]  led_col_q, led_col_d;
  logic [RowW-1:0]  led_row_q, led_row_d;

  logic [SideW-1:0] sc, sr, cp, rp;
  logic [ColW-1:0]  lc;
  logic [RowW-1:0]  lr;
  logic             accept, is_pixel, emit;
  logic [31:0]      pos_full;

  assign full     = queue_full_i;
  assign accept   = push && !full;
  assign is_pixel = !action_i;

  // Clear position on frame start
  assign sc = frame_start_i ? '0 : src_col_q;
  assign sr = frame_start_i ? '0 : src_row_q;
  assign cp = frame_start_i ? '0 : col_ph_q;
  assign rp = frame_start_i ? '0 : row_ph_q;
  assign lc = frame_start_i ? '0 : led_col_q;
  assign lr = frame_start_i ? '0 : led_row_q;

  // Cell center test
  assign emit = (cell_w_i != '0) && (cell_h_i != '0) &&
                (lc < ColW'(LED_COLUMNS)) && (lr < RowW'(LED_ROWS)) &&
                (cp == (cell_w_i >> 1)) && (rp == (cell_h_i >> 1));

  assign pos_full = 32'(lr) * 32'(LED_COLUMNS) + 32'(lc);

  // Build queue item
  always_comb begin
    item_o.is_load = action_i;
    item_o.chan    = table_channel_i;
    item_o.idx     = table_index_i;
    item_o.val     = table_value_i;
    item_o.red     = pixel_red_i;
    item_o.green   = pixel_green_i;
    item_o.blue    = pixel_blue_i;
    item_o.pos     = pos_full[7:0];
    item_o.last    = (lc == ColW'(LED_COLUMNS - 1)) && (lr == RowW'(LED_ROWS - 1));
  end

  // Drop loads to the unused channel and pixels off the cell centers
  assign enq_o = accept && (is_pixel ? emit : (table_channel_i != 2'd3));

  // Advance raster position
  always_comb begin
    logic [SideW:0] sc_n, cp_n, sr_n, rp_n;
    logic [ColW-1:0] lc_n;
    logic [RowW-1:0] lr_n;
    sc_n = {1'b0, sc} + 1'b1;
    cp_n = {1'b0, cp} + 1'b1;
    sr_n = {1'b0, sr};
    rp_n = {1'b0, rp};
    lc_n = lc;
    lr_n = lr;
    if ((cell_w_i != '0) && (cp_n >= {1'b0, cell_w_i})) begin
      cp_n = '0;
      if (lc < ColW'(LED_COLUMNS)) begin
        lc_n = lc + 1'b1;
      end
    end
    if (sc_n >= {1'b0, width_i}) begin
      sc_n = '0;
      cp_n = '0;
      lc_n = '0;
      sr_n = {1'b0, sr} + 1'b1;
      rp_n = {1'b0, rp} + 1'b1;
      if ((cell_h_i != '0) && (rp_n >= {1'b0, cell_h_i})) begin
        rp_n = '0;
        if (lr < RowW'(LED_ROWS)) begin
          lr_n = lr + 1'b1;
        end
      end
      if (sr_n >= {1'b0, height_i}) begin
        sr_n = '0;
        rp_n = '0;
        lr_n = '0;
      end
    end
    if (cp_n >= (SideW+1)'(MAX_SOURCE_SIDE)) begin
      cp_n = '0;
    end
    if (rp_n >= (SideW+1)'(MAX_SOURCE_SIDE)) begin
      rp_n = '0;
    end
    src_col_d = sc_n[SideW-1:0];
    col_ph_d  = cp_n[SideW-1:0];
    src_row_d = sr_n[SideW-1:0];
    row_ph_d  = rp_n[SideW-1:0];
    led_col_d = lc_n;
    led_row_d = lr_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      col_ph_q  <= '0;
      row_ph_q  <= '0;
      led_col_q <= '0;
      led_row_q <= '0;
    end else if (accept && is_pixel) begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      col_ph_q  <= col_ph_d;
      row_ph_q  <= row_ph_d;
      led_col_q <= led_col_d;
      led_row_q <= led_row_d;
    end
  end

endmodule

`default_nettype wire

[hdl/lfsg_back.sv]
// ----------------------------------------------------------------------------
// lfsg_back
// Color pipeline: gain, brightness, gamma lookup, then the result queue.
// Table loads travel the same stages so they stay in order with pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsg_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  lfsg_pkg::corr_cfg_t       corr_i,
  input  lfsg_pkg::item_t           head_i,
  input  wire logic                 head_empty_i,
  output logic                      head_pop_o,
  output lfsg_pkg::out_t            result_o,
  output logic                      empty,
  input  wire logic                 pop
);

  localparam int Depth = lfsg_pkg::OutDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  // Stage registers
  logic            v1_q, v2_q, v3_q;
  lfsg_pkg::item_t s1_q, s2_q;
  logic [23:0]     p1_r_q, p1_g_q, p1_b_q;
  logic [16:0]     p2_r_q, p2_g_q, p2_b_q;
  logic            s3_load_q;
  logic [7:0]      s3_pos_q;
  logic            s3_last_q;
  logic [7:0]      rd_r_q, rd_g_q, rd_b_q;

  // Gamma tables, one per channel
  logic [7:0] gam_r_q [256];
  logic [7:0] gam_g_q [256];
  logic [7:0] gam_b_q [256];

  // Result queue
  lfsg_pkg::out_t  out_mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] owed_q, owed_d;

  logic            issue, out_push, out_pop;
  logic [7:0]      sat_r, sat_g, sat_b;
  logic [7:0]      lum_r, lum_g, lum_b;
  lfsg_pkg::out_t  out_item;

  // Issue loads freely; issue pixels when a result slot is reserved for every pixel in flight
  assign issue      = !head_empty_i && (head_i.is_load || (owed_q < CntW'(Depth)));
  assign head_pop_o = issue;

  // Saturate gain products to 255
  assign sat_r = (p1_r_q[23:16] != 8'd0) ? 8'hFF : p1_r_q[15:8];
  assign sat_g = (p1_g_q[23:16] != 8'd0) ? 8'hFF : p1_g_q[15:8];
  assign sat_b = (p1_b_q[23:16] != 8'd0) ? 8'hFF : p1_b_q[15:8];

  // Drop the brightness fraction
  assign lum_r = p2_r_q[15:8];
  assign lum_g = p2_g_q[15:8];
  assign lum_b = p2_b_q[15:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Gain, brightness and tag stages
  always_ff @(posedge clk_i) begin
    s1_q      <= head_i;
    p1_r_q    <= 24'(head_i.red)   * 24'(corr_i.red_gain);
    p1_g_q    <= 24'(head_i.green) * 24'(corr_i.green_gain);
    p1_b_q    <= 24'(head_i.blue)  * 24'(corr_i.blue_gain);
    s2_q      <= s1_q;
    p2_r_q    <= 17'(sat_r) * 17'(corr_i.brightness);
    p2_g_q    <= 17'(sat_g) * 17'(corr_i.brightness);
    p2_b_q    <= 17'(sat_b) * 17'(corr_i.brightness);
    s3_load_q <= s2_q.is_load;
    s3_pos_q  <= s2_q.pos;
    s3_last_q <= s2_q.last;
  end

  // Gamma lookup and table load
  always_ff @(posedge clk_i) begin
    rd_r_q <= gam_r_q[lum_r];
    rd_g_q <= gam_g_q[lum_g];
    rd_b_q <= gam_b_q[lum_b];
    if (v2_q && s2_q.is_load) begin
      priority if (s2_q.chan == lfsg_pkg::ChanRed) begin
        gam_r_q[s2_q.idx] <= s2_q.val;
      end else if (s2_q.chan == lfsg_pkg::ChanGreen) begin
        gam_g_q[s2_q.idx] <= s2_q.val;
      end else if (s2_q.chan == lfsg_pkg::ChanBlue) begin
        gam_b_q[s2_q.idx] <= s2_q.val;
      end
    end
  end

  // Result queue
  assign out_push = v3_q && !s3_load_q;
  assign out_pop  = pop && !empty;
  assign empty    = (count_q == '0);
  assign result_o = out_mem_q[rd_ptr_q];

  always_comb begin
    out_item.red   = rd_r_q;
    out_item.green = rd_g_q;
    out_item.blue  = rd_b_q;
    out_item.pos   = s3_pos_q;
    out_item.last  = s3_last_q;
  end

  always_comb begin
    count_d = count_q;
    if (out_push && !out_pop) begin
      count_d = count_q + 1'b1;
    end else if (out_pop && !out_push) begin
      count_d = count_q - 1'b1;
    end
    owed_d = owed_q;
    if ((issue && !head_i.is_load) && !out_pop) begin
      owed_d = owed_q + 1'b1;
    end else if (out_pop && !(issue && !head_i.is_load)) begin
      owed_d = owed_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      owed_q   <= '0;
    end else begin
      if (out_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (out_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
      owed_q  <= owed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[wr_ptr_q] <= out_item;
    end
  end

endmodule

`default_nettype wire

[hdl/led_frame_sample_color_gamma_top.sv]
// ----------------------------------------------------------------------------
// led_frame_sample_color_gamma_top
// Samples a raster RGB frame at LED cell centers and color corrects it.
// ----------------------------------------------------------------------------
// Items enter through a queue style port (push/full) and results leave the
// same way (empty/pop). A source pixel or a gamma table load is accepted
// every clock while the four entry front queue has room; the front end
// works out the pixel position combinationally, and the back end runs a three
// stage pipeline (gain multiply, brightness multiply, gamma table read) into
// a result queue; one result per clock leaves while pop is held high and the
// queue is not empty. Loads must fill all three gamma tables before the
// first pixel. Configuration writes take effect at once; the user must make
// them only while the block holds no work, which the block does not enforce.
`default_nettype none

module led_frame_sample_color_gamma_top #(
  parameter int LED_COLUMNS     = lfsg_pkg::LedColumnsDef,
  parameter int LED_ROWS        = lfsg_pkg::LedRowsDef,
  parameter int MAX_SOURCE_SIDE = lfsg_pkg::MaxSourceSideDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_write_i,
  input  wire logic [lfsg_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [lfsg_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           action_i,
  input  wire logic                           frame_start_i,
  input  wire logic [7:0]                     pixel_red_i,
  input  wire logic [7:0]                     pixel_green_i,
  input  wire logic [7:0]                     pixel_blue_i,
  input  wire logic [1:0]                     table_channel_i,
  input  wire logic [7:0]                     table_index_i,
  input  wire logic [7:0]                     table_value_i,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [7:0]                          led_red_o,
  output logic [7:0]                          led_green_o,
  output logic [7:0]                          led_blue_o,
  output logic [7:0]                          led_position_o,
  output logic                                frame_last_o
);

  localparam int SideW = $clog2(MAX_SOURCE_SIDE + 1);
  localparam int ItemW = $bits(lfsg_pkg::item_t);

  logic [SideW-1:0]    width, height, cell_w, cell_h;
  lfsg_pkg::corr_cfg_t corr;
  logic                enq, mid_full, mid_empty, mid_pop;
  lfsg_pkg::item_t     enq_item, head_item;
  logic [ItemW-1:0]    head_bits;
  lfsg_pkg::out_t      result;

  lfsg_cfg #(
    .LED_COLUMNS     (LED_COLUMNS),
    .LED_ROWS        (LED_ROWS),
    .MAX_SOURCE_SIDE (MAX_SOURCE_SIDE)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_write (cfg_write_i),
    .cfg_index (cfg_index_i),
    .cfg_data  (cfg_data_i),
    .width_o   (width),
    .height_o  (height),
    .cell_w_o  (cell_w),
    .cell_h_o  (cell_h),
    .corr_o    (corr)
  );

  lfsg_front #(
    .LED_COLUMNS     (LED_COLUMNS),
    .LED_ROWS        (LED_ROWS),
    .MAX_SOURCE_SIDE (MAX_SOURCE_SIDE)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .action_i        (action_i),
    .frame_start_i   (frame_start_i),
    .pixel_red_i     (pixel_red_i),
    .pixel_green_i   (pixel_green_i),
    .pixel_blue_i    (pixel_blue_i),
    .table_channel_i (table_channel_i),
    .table_index_i   (table_index_i),
    .table_value_i   (table_value_i),
    .width_i         (width),
    .height_i        (height),
    .cell_w_i        (cell_w),
    .cell_h_i        (cell_h),
    .enq_o           (enq),
    .item_o          (enq_item),
    .queue_full_i    (mid_full)
  );

  lfsg_fifo #(
    .Width (ItemW),
    .Depth (lfsg_pkg::MidDepth)
  ) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (enq),
    .data_i  (enq_item),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (head_bits),
    .empty_o (mid_empty)
  );

  assign head_item = lfsg_pkg::item_t'(head_bits);

  lfsg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .corr_i       (corr),
    .head_i       (head_item),
    .head_empty_i (mid_empty),
    .head_pop_o   (mid_pop),
    .result_o     (result),
    .empty        (empty),
    .pop          (pop)
  );

  assign led_red_o      = result.red;
  assign led_green_o    = result.green;
  assign led_blue_o     = result.blue;
  assign led_position_o = result.pos;
  assign frame_last_o   = result.last;

endmodule

`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED frame sampler with gain, brightness and gamma.
// ----------------------------------------------------------------------------
// A shadow sampler tracks the raster position, the LED cell and the gamma
// tables. It works out the LED value that each accepted pixel should give.
// A checker process pops results at random and compares every field with the
// oldest pending LED value. The tests fill the gamma tables first. They then
// run the reset frame size, a short set of directed pixels, a series of frame
// shapes (leftover pixels, small, masked, clamped and overrun frames), and
// long random frame streams with load items and broken frames mixed in.
// ----------------------------------------------------------------------------

module testbench;

  import lfsg_pkg::*;

  localparam int Cols         = LedColumnsDef;
  localparam int Rows         = LedRowsDef;
  localparam int MaxSide      = MaxSourceSideDef;
  localparam int SettleCycles = 16;
  localparam int QuietLimit   = 1000;
  localparam int MaxPrinted   = 40;
  localparam int RandomItems  = 1200;
  localparam int SendSide     = 0;
  localparam int PopSide      = 1;

  // Item kinds and the table code that no table answers to
  localparam logic       ActPixel = 1'b0;
  localparam logic       ActLoad  = 1'b1;
  localparam logic [1:0] ChanNone = 2'd3;

  typedef struct packed {
    logic       action;
    logic       frame_start;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] chan;
    logic [7:0] idx;
    logic [7:0] val;
  } stream_item_t;

  // Block ports
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_write_i     = 1'b0;
  reg_index_e  cfg_index_i     = RegSourceWidth;
  logic [15:0] cfg_data_i      = '0;
  logic        push            = 1'b0;
  logic        full;
  logic        action_i        = ActPixel;
  logic        frame_start_i   = 1'b0;
  logic [7:0]  pixel_red_i     = '0;
  logic [7:0]  pixel_green_i   = '0;
  logic [7:0]  pixel_blue_i    = '0;
  logic [1:0]  table_channel_i = ChanRed;
  logic [7:0]  table_index_i   = '0;
  logic [7:0]  table_value_i   = '0;
  logic        empty;
  logic        pop             = 1'b0;
  logic [7:0]  led_red_o;
  logic [7:0]  led_green_o;
  logic [7:0]  led_blue_o;
  logic [7:0]  led_position_o;
  logic        frame_last_o;

  // Shadow copy of the registers, the gamma tables and the raster position
  logic [12:0] cfg_width  = SideRst;
  logic [12:0] cfg_height = SideRst;
  logic [15:0] cfg_gain [3] = '{GainRst, GainRst, GainRst};
  logic [8:0]  cfg_bright = BrightMax;
  logic [7:0]  gamma_shadow [768];
  int unsigned src_col, src_row, col_phase, row_phase, led_col, led_row;

  out_t        pending_leds [$];
  int unsigned err_count    = 0;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;
  bit          rush [2]     = '{1'b0, 1'b0};

  led_frame_sample_color_gamma_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_write_i     (cfg_write_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .action_i        (action_i),
    .frame_start_i   (frame_start_i),
    .pixel_red_i     (pixel_red_i),
    .pixel_green_i   (pixel_green_i),
    .pixel_blue_i    (pixel_blue_i),
    .table_channel_i (table_channel_i),
    .table_index_i   (table_index_i),
    .table_value_i   (table_value_i),
    .empty           (empty),
    .pop             (pop),
    .led_red_o       (led_red_o),
    .led_green_o     (led_green_o),
    .led_blue_o      (led_blue_o),
    .led_position_o  (led_position_o),
    .frame_last_o    (frame_last_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // End the run when no item moves on either side for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Shadow sampler
  // --------------------------------------------------------------------------

  function automatic int unsigned clamp_side(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MaxSide) return MaxSide;
    return v;
  endfunction

  // Gain with saturation, brightness, then gamma lookup
  function automatic logic [7:0] color_correct(logic [7:0] c, logic [15:0] gain,
                                               logic [1:0] chan);
    logic [23:0] gained;
    logic [7:0]  sat;
    logic [8:0]  bright;
    logic [16:0] dimmed;
    gained = c * gain;
    sat    = (gained[23:8] > 16'd255) ? 8'hFF : gained[15:8];
    bright = (cfg_bright > BrightMax) ? BrightMax : cfg_bright;
    dimmed = sat * bright;
    return gamma_shadow[chan * 256 + dimmed[15:8]];
  endfunction

  // Apply one item; queue the LED value when the pixel is a cell center
  function automatic void predict_led(stream_item_t it);
    int unsigned w, h, cw, chh;
    out_t        led;
    if (it.action == ActLoad) begin
      if (it.chan != ChanNone) gamma_shadow[it.chan * 256 + it.idx] = it.val;
      return;
    end
    if (it.frame_start) begin
      src_col   = 0;
      src_row   = 0;
      col_phase = 0;
      row_phase = 0;
      led_col   = 0;
      led_row   = 0;
    end
    w   = clamp_side(cfg_width);
    h   = clamp_side(cfg_height);
    cw  = w / Cols;
    chh = h / Rows;
    if (cw != 0 && chh != 0 && led_col < Cols && led_row < Rows &&
        col_phase == cw / 2 && row_phase == chh / 2) begin
      led.red   = color_correct(it.red, cfg_gain[0], ChanRed);
      led.green = color_correct(it.green, cfg_gain[1], ChanGreen);
      led.blue  = color_correct(it.blue, cfg_gain[2], ChanBlue);
      led.pos   = 8'(led_row * Cols + led_col);
      led.last  = (led_col == Cols - 1) && (led_row == Rows - 1);
      pending_leds.push_back(led);
    end
    // Advance the raster position; LED counters hold once past the last cell
    src_col++;
    col_phase++;
    if (cw != 0 && col_phase >= cw) begin
      col_phase = 0;
      if (led_col < Cols) led_col++;
    end
    if (src_col >= w) begin
      src_col   = 0;
      col_phase = 0;
      led_col   = 0;
      src_row++;
      row_phase++;
      if (chh != 0 && row_phase >= chh) begin
        row_phase = 0;
        if (led_row < Rows) led_row++;
      end
      if (src_row >= h) begin
        src_row   = 0;
        row_phase = 0;
        led_row   = 0;
      end
    end
    if (col_phase >= MaxSide) col_phase = 0;
    if (row_phase >= MaxSide) row_phase = 0;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Draw the wait for one side at random, with runs of back to back items
  function automatic int draw_wait(int side);
    if ($urandom_range(0, 47) == 0) rush[side] = !rush[side];
    return rush[side] ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [7:0] rand_color();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic stream_item_t make_pixel(logic mark, logic [7:0] r, logic [7:0] g,
                                              logic [7:0] b);
    stream_item_t it;
    it.action      = ActPixel;
    it.frame_start = mark;
    it.red         = r;
    it.green       = g;
    it.blue        = b;
    it.chan        = 2'($urandom);
    it.idx         = 8'($urandom);
    it.val         = 8'($urandom);
    return it;
  endfunction

  function automatic stream_item_t make_load(logic mark, logic [1:0] chan, logic [7:0] idx,
                                             logic [7:0] val);
    stream_item_t it;
    it.action      = ActLoad;
    it.frame_start = mark;
    it.red         = 8'($urandom);
    it.green       = 8'($urandom);
    it.blue        = 8'($urandom);
    it.chan        = chan;
    it.idx         = idx;
    it.val         = val;
    return it;
  endfunction

  // Send one item and predict it at the edge that takes it
  task automatic push_item(input stream_item_t it);
    int gap;
    gap = draw_wait(SendSide);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push            <= 1'b1;
    action_i        <= it.action;
    frame_start_i   <= it.frame_start;
    pixel_red_i     <= it.red;
    pixel_green_i   <= it.green;
    pixel_blue_i    <= it.blue;
    table_channel_i <= it.chan;
    table_index_i   <= it.idx;
    table_value_i   <= it.val;
    do @(posedge clk_i); while (full);
    predict_led(it);
    if (!(it.action == ActLoad && it.chan == ChanNone)) items_sent++;
  endtask

  task automatic send_pixels(int count, bit mark_first);
    for (int i = 0; i < count; i++) begin
      push_item(make_pixel(mark_first && i == 0, rand_color(), rand_color(), rand_color()));
    end
  endtask

  // Hold the input side until all results are out and the pipeline is empty
  task automatic settle_idle();
    push <= 1'b0;
    while (pending_leds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Leaves the write enable high; write_regs drops it after the last one
  task automatic write_reg(reg_index_e idx, logic [15:0] data);
    cfg_write_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      RegSourceWidth:  cfg_width   = data[12:0];
      RegSourceHeight: cfg_height  = data[12:0];
      RegRedGain:      cfg_gain[0] = data;
      RegGreenGain:    cfg_gain[1] = data;
      RegBlueGain:     cfg_gain[2] = data;
      RegBrightness:   cfg_bright  = data[8:0];
      default: ;
    endcase
  endtask

  task automatic write_regs(logic [15:0] width, logic [15:0] height, logic [15:0] rg,
                            logic [15:0] gg, logic [15:0] bg, logic [15:0] bright);
    write_reg(RegSourceWidth, width);
    write_reg(RegSourceHeight, height);
    write_reg(RegRedGain, rg);
    write_reg(RegGreenGain, gg);
    write_reg(RegBlueGain, bg);
    write_reg(RegBrightness, bright);
    cfg_write_i <= 1'b0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    // Cap the log, keep counting
    if (err_count <= MaxPrinted) begin
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------

  initial begin : result_check
    int   stall;
    out_t want;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = draw_wait(PopSide);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (pending_leds.size() == 0) begin
        report_mismatch("result with no pixel pending, position", led_position_o, -1);
      end else begin
        want = pending_leds.pop_front();
        if (led_red_o !== want.red) report_mismatch("red", led_red_o, want.red);
        if (led_green_o !== want.green) report_mismatch("green", led_green_o, want.green);
        if (led_blue_o !== want.blue) report_mismatch("blue", led_blue_o, want.blue);
        if (led_position_o !== want.pos) begin
          report_mismatch("position", led_position_o, want.pos);
        end
        if (frame_last_o !== want.last) report_mismatch("frame last", frame_last_o, want.last);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fill every entry of all three tables; loads to the missing table are dropped
  task automatic test_gamma_load();
    logic [1:0] chans [3];
    chans = '{ChanRed, ChanGreen, ChanBlue};
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 256; i++) begin
        push_item(make_load(1'($urandom), chans[c], 8'(i), rand_color()));
      end
    end
    for (int i = 0; i < 4; i++) begin
      push_item(make_load(1'($urandom), ChanNone, 8'($urandom), 8'($urandom)));
    end
  endtask

  // Reset sizes: 64 by 64 frame, cell centers on row 2
  task automatic test_reset_frame();
    send_pixels(64 * 4, 1'b1);
  endtask

  task automatic test_directed_pixels();
    // Saturating red gain, unity green, zero blue
    settle_idle();
    write_regs(16'd16, 16'd16, 16'hFFFF, 16'h0100, 16'h0000, 16'd256);
    push_item(make_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF));
    push_item(make_pixel(1'b0, 8'h00, 8'h00, 8'h00));
    push_item(make_pixel(1'b0, 8'h01, 8'h80, 8'hFF));
    push_item(make_pixel(1'b0, 8'h80, 8'hFE, 8'h7F));
    // A load item ignores its frame mark; the new entry is used right away
    push_item(make_load(1'b1, ChanGreen, 8'h80, 8'h5A));
    push_item(make_pixel(1'b0, 8'h80, 8'h80, 8'h80));
    push_item(make_load(1'b0, ChanNone, 8'hFF, 8'h00));
    push_item(make_pixel(1'b0, 8'hFF, 8'h00, 8'hFF));

    // Zero brightness sends every channel to entry zero
    settle_idle();
    write_regs(16'd16, 16'd16, 16'h0080, 16'h01FF, 16'h8000, 16'd0);
    push_item(make_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF));
    push_item(make_pixel(1'b0, 8'h55, 8'hAA, 8'h01));
    push_item(make_pixel(1'b0, 8'h00, 8'h00, 8'h00));

    // Brightness above full, and a frame mark in mid frame
    settle_idle();
    write_regs(16'd16, 16'd16, 16'h0100, 16'h0200, 16'h0001, 16'h01FF);
    push_item(make_pixel(1'b1, 8'hFF, 8'h7F, 8'hFF));
    push_item(make_pixel(1'b0, 8'h10, 8'h80, 8'hFE));
    push_item(make_pixel(1'b1, 8'hAA, 8'h55, 8'h00));
    push_item(make_pixel(1'b0, 8'h01, 8'hFF, 8'h80));

    // Brightness just above and just below full
    settle_idle();
    write_regs(16'd16, 16'd16, 16'h0180, 16'h00FF, 16'h0101, 16'd257);
    push_item(make_pixel(1'b1, 8'hC0, 8'hFF, 8'hFF));
    push_item(make_pixel(1'b0, 8'h40, 8'h02, 8'h9F));
    settle_idle();
    write_regs(16'd16, 16'd16, 16'h0100, 16'h0100, 16'h0100, 16'd255);
    push_item(make_pixel(1'b1, 8'hFF, 8'h80, 8'h01));
    push_item(make_pixel(1'b0, 8'h02, 8'hFE, 8'h7F));
  endtask

  task automatic test_frame_shapes();
    // Whole 16 by 16 frame, then overrun that wraps without a mark
    settle_idle();
    write_regs(16'd16, 16'd16, 16'h0100, 16'h0100, 16'h0100, 16'd256);
    send_pixels(16 * 16 + 40, 1'b1);

    // Leftover columns and rows beyond the last whole cell
    settle_idle();
    write_regs(16'd40, 16'd20, 16'h00C0, 16'h0140, 16'h0233, 16'd200);
    send_pixels(40 * 20 + 10, 1'b1);

    // Frames smaller than the LED grid give nothing
    settle_idle();
    write_regs(16'd8, 16'd64, 16'h0100, 16'h0100, 16'h0100, 16'd256);
    send_pixels(80, 1'b1);
    settle_idle();
    write_regs(16'd0, 16'd0, 16'hFFFF, 16'h0000, 16'h8001, 16'd128);
    send_pixels(12, 1'b1);
    settle_idle();
    write_regs(16'd16, 16'd15, 16'h0100, 16'h0100, 16'h0100, 16'd256);
    send_pixels(40, 1'b1);

    // Upper data bits fall outside the size registers
    settle_idle();
    write_regs(16'hE010, 16'hE011, 16'h0100, 16'h0100, 16'h0100, 16'hFF00);
    send_pixels(16 * 17 + 16, 1'b1);

    // Sizes above the largest side are clamped
    settle_idle();
    write_regs(16'h1FFF, 16'd16, 16'h0100, 16'h0300, 16'h0080, 16'd256);
    send_pixels(MaxSide + 20, 1'b1);
    settle_idle();
    write_regs(16'd16, 16'h1FFF, 16'h0100, 16'h0100, 16'h0100, 16'd256);
    send_pixels(16 * 130, 1'b1);
  endtask

  // Frames of random content with loads, early marks and overruns mixed in
  task automatic test_random_streams();
    int unsigned goal, w, h, run;
    bit          wide, mark;
    logic [15:0] gains [3];
    logic [15:0] bright;
    goal = items_sent + RandomItems;
    while (items_sent < goal) begin
      wide = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 15) == 0) begin
        w = $urandom_range(1, 15);
        h = $urandom_range(16, 20);
      end else if (wide) begin
        w = $urandom_range(64, 160);
        h = 16;
      end else begin
        w = $urandom_range(16, 24);
        h = $urandom_range(16, 18);
      end
      for (int c = 0; c < 3; c++) begin
        gains[c] = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 512));
      end
      bright = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 511))
                                           : 16'($urandom_range(0, 256));
      settle_idle();
      write_regs(16'(w), 16'(h), gains[0], gains[1], gains[2], bright);
      run  = wide ? 3 * w : w * h;
      // Most frames start with a mark; some follow on from an overrun
      mark = ($urandom_range(0, 3) != 0);
      for (int frame = 0; frame < 2; frame++) begin
        for (int unsigned p = 0; p < run; p++) begin
          if ($urandom_range(0, 15) == 0) begin
            push_item(make_load(1'($urandom), 2'($urandom), 8'($urandom), rand_color()));
          end
          if ($urandom_range(0, 63) == 0) begin
            push_item(make_pixel(1'b1, rand_color(), rand_color(), rand_color()));
          end else begin
            push_item(make_pixel(mark && p == 0, rand_color(), rand_color(), rand_color()));
          end
        end
        mark = ($urandom_range(0, 3) != 0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_gamma_load();
    test_reset_frame();
    test_directed_pixels();
    test_frame_shapes();
    test_random_streams();
    settle_idle();
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
